>>> design/stc_pkg.sv
`default_nettype none
package stc_pkg;

    localparam int SAMPLE_RATE = 44100;
    // accumulator step per sample for a 256 Hz frame clock
    localparam int FRAME_STEP  = (1 << 24) / SAMPLE_RATE;

    localparam int Q_W   = 24;              // quotient bits of the step divider
    localparam int DEN_W = 28;              // SAMPLE_RATE * 2048 fits here
    localparam int REM0  = 1 << (36 - Q_W); // dividend bits above the quotient
    localparam int MUL_N = 13;              // bits of the channel weight

    // command codes
    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    // config register indexes
    localparam logic [2:0] REG_DUTY   = 3'd0;
    localparam logic [2:0] REG_ROUTE  = 3'd1;
    localparam logic [2:0] REG_LEFT   = 3'd2;
    localparam logic [2:0] REG_RIGHT  = 3'd3;
    localparam logic [2:0] REG_MASTER = 3'd4;
    localparam logic [2:0] REG_SWEEP  = 3'd5;
    localparam logic [2:0] REG_ENV    = 3'd6;
    localparam logic [2:0] REG_LENGTH = 3'd7;

    function automatic logic [7:0] duty_pattern(input logic [1:0] sel);
        case (sel)
            2'd0:    duty_pattern = 8'h10;
            2'd1:    duty_pattern = 8'h30;
            2'd2:    duty_pattern = 8'h3C;
            default: duty_pattern = 8'hCF;
        endcase
    endfunction

    // level*16384/15, rounded down
    function automatic logic [14:0] env_weight(input logic [3:0] lvl);
        case (lvl)
            4'd0:    env_weight = 15'd0;
            4'd1:    env_weight = 15'd1092;
            4'd2:    env_weight = 15'd2184;
            4'd3:    env_weight = 15'd3276;
            4'd4:    env_weight = 15'd4369;
            4'd5:    env_weight = 15'd5461;
            4'd6:    env_weight = 15'd6553;
            4'd7:    env_weight = 15'd7645;
            4'd8:    env_weight = 15'd8738;
            4'd9:    env_weight = 15'd9830;
            4'd10:   env_weight = 15'd10922;
            4'd11:   env_weight = 15'd12014;
            4'd12:   env_weight = 15'd13107;
            4'd13:   env_weight = 15'd14199;
            4'd14:   env_weight = 15'd15291;
            default: env_weight = 15'd16384;
        endcase
    endfunction

    // level*4096/7, rounded down
    function automatic logic [12:0] chan_weight(input logic [2:0] lvl);
        case (lvl)
            3'd0:    chan_weight = 13'd0;
            3'd1:    chan_weight = 13'd585;
            3'd2:    chan_weight = 13'd1170;
            3'd3:    chan_weight = 13'd1755;
            3'd4:    chan_weight = 13'd2340;
            3'd5:    chan_weight = 13'd2925;
            3'd6:    chan_weight = 13'd3510;
            default: chan_weight = 13'd4096;
        endcase
    endfunction

endpackage
`default_nettype wire

>>> design/stc_divider.sv
`default_nettype none
// Bit-serial divider: phase step = 2^36 / (SAMPLE_RATE * (2048 - rate)).
// Forms the divisor on start, then produces one quotient bit per cycle.
module stc_divider (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [10:0]           rate,
    output logic                       busy,
    output logic                       done,
    output logic [stc_pkg::Q_W-1:0]    quotient
);
    localparam logic [16:0] SR = 17'(stc_pkg::SAMPLE_RATE);

    logic                        busy_reg;
    logic [4:0]                  cnt_reg;
    logic [stc_pkg::DEN_W-1:0]   den_reg;
    logic [stc_pkg::DEN_W-1:0]   rem_reg;
    logic [stc_pkg::Q_W-1:0]     q_reg;
    logic [stc_pkg::DEN_W:0]     trial;
    logic                        fits;
    logic [11:0]                 diff;

    assign diff  = 12'd2048 - {1'b0, rate};
    assign trial = {rem_reg, 1'b0};
    assign fits  = trial >= {1'b0, den_reg};

    // iterate restoring division
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'(stc_pkg::Q_W - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= stc_pkg::DEN_W'(SR) * stc_pkg::DEN_W'(diff);
            rem_reg <= stc_pkg::DEN_W'(stc_pkg::REM0);
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? stc_pkg::DEN_W'(trial - {1'b0, den_reg})
                            : stc_pkg::DEN_W'(trial);
            q_reg   <= {q_reg[stc_pkg::Q_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign done     = busy_reg && (cnt_reg == 5'(stc_pkg::Q_W - 1));
    assign quotient = {q_reg[stc_pkg::Q_W-2:0], fits};

endmodule
`default_nettype wire

>>> design/square_tone_channel.sv
// Square tone channel with sweep, envelope and length counter.
// Input channel (s_valid/s_ready): command 0 is a sample tick, 1 restarts the
// channel with s_start_rate. Every transaction gives one result transaction
// on m_valid/m_ready: signed left/right samples and the active flag.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr;
// write only while the block is idle.
// Sequence: accept, bit-serial volume multiply, then output register.
// A restart, or a tick on which the sweep changes the rate, also runs the
// bit-serial step divider before the output (the divisor is formed in the last
// multiply cycle, then 24 quotient bits), so the divider sets the worst case.
// One item is in work at a time; s_ready is high while the sequencer is idle,
// also while the last result waits in the output register.
// If the receiver stalls, the finished result holds the sequencer until the
// output register is free.
// Reset (aresetn low, synchronous) silences the channel, clears the channel
// counters and sets the duty to 50 percent with all other config registers zero.
`default_nettype none
module square_tone_channel (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_addr,
    input  wire logic [8:0]        cfg_wdata,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_command,
    input  wire logic [10:0]       s_start_rate,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic signed [9:0]      m_left_sample,
    output logic signed [9:0]      m_right_sample,
    output logic                   m_active
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_OUT  = 3'd3;

    // config registers
    logic [1:0] duty_reg, route_reg, master_reg;
    logic [2:0] left_lvl_reg, right_lvl_reg;
    logic [7:0] sweep_ctl_reg;
    logic [8:0] env_ctl_reg;
    logic [6:0] len_ctl_reg;

    // channel state
    logic [18:0] phase_reg, phase_next;
    logic [23:0] step_reg;
    logic [15:0] facc_reg, facc_next;
    logic [6:0]  len_reg, len_next;
    logic [3:0]  env_reg, env_next;
    logic [2:0]  env_cd_reg, env_cd_next;
    logic [2:0]  sw_cd_reg, sw_cd_next;
    logic [10:0] rate_reg, rate_next;
    logic        snd_reg, snd_next;

    // sequencer and datapath
    logic [2:0]  state_reg, state_next;
    logic        div_req_reg, div_req_next;
    logic        high_reg, high_next;
    logic [27:0] mcand_reg;
    logic [14:0] e_next;
    logic [12:0] cl_reg, cr_reg, cl_next, cr_next;
    logic [27:0] pl_reg, pr_reg;
    logic [3:0]  mcnt_reg;
    logic        accept;

    logic        m_valid_reg;
    logic [9:0]  ml_reg, mr_reg;
    logic        ma_reg;
    logic        out_free;

    logic        div_start, div_busy, div_done;
    logic [23:0] div_q;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_reg <= 2'd2; route_reg <= '0; master_reg <= '0;
            left_lvl_reg <= '0; right_lvl_reg <= '0;
            sweep_ctl_reg <= '0; env_ctl_reg <= '0; len_ctl_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                stc_pkg::REG_DUTY:   duty_reg      <= cfg_wdata[1:0];
                stc_pkg::REG_ROUTE:  route_reg     <= cfg_wdata[1:0];
                stc_pkg::REG_LEFT:   left_lvl_reg  <= cfg_wdata[2:0];
                stc_pkg::REG_RIGHT:  right_lvl_reg <= cfg_wdata[2:0];
                stc_pkg::REG_MASTER: master_reg    <= cfg_wdata[1:0];
                stc_pkg::REG_SWEEP:  sweep_ctl_reg <= cfg_wdata[7:0];
                stc_pkg::REG_ENV:    env_ctl_reg   <= cfg_wdata;
                stc_pkg::REG_LENGTH: len_ctl_reg   <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // item decode, phase advance and frame clock
    always_comb begin
        logic [16:0] fsum;
        logic [6:0]  len_t;
        logic [2:0]  cd;
        logic [10:0] shifted;
        logic [11:0] r12;
        logic        stop;
        logic [7:0]  pat;
        fsum = {1'b0, facc_reg} + 17'(stc_pkg::FRAME_STEP);
        len_t = len_reg - 7'd1;
        cd = '0; shifted = '0; r12 = '0; stop = 1'b0; pat = '0;
        phase_next = phase_reg; facc_next = facc_reg; len_next = len_reg;
        env_next = env_reg; env_cd_next = env_cd_reg; sw_cd_next = sw_cd_reg;
        rate_next = rate_reg; snd_next = snd_reg;
        div_req_next = div_req_reg; high_next = high_reg;
        e_next = '0; cl_next = '0; cr_next = '0;
        if (accept) begin
            div_req_next = 1'b0;
            high_next = 1'b0;
            if (s_command == stc_pkg::CMD_RESTART) begin
                rate_next = s_start_rate;
                phase_next = '0;
                facc_next = '0;
                len_next = (len_ctl_reg[5:0] == 6'd0) ? 7'd64 : {1'b0, len_ctl_reg[5:0]};
                env_next = env_ctl_reg[3:0];
                env_cd_next = env_ctl_reg[6:4];
                sw_cd_next = sweep_ctl_reg[2:0];
                snd_next = 1'b1;
                div_req_next = 1'b1;
            end else if (snd_reg && route_reg != 2'd0) begin
                pat = stc_pkg::duty_pattern(duty_reg);
                high_next = pat[phase_reg[18:16]];
                e_next = stc_pkg::env_weight(env_reg);
                cl_next = route_reg[0] ? stc_pkg::chan_weight(left_lvl_reg) : '0;
                cr_next = route_reg[1] ? stc_pkg::chan_weight(right_lvl_reg) : '0;
                phase_next = phase_reg + step_reg[18:0];
                facc_next = fsum[15:0];
                if (fsum[16]) begin
                    // length counter
                    if (len_ctl_reg[6]) begin
                        len_next = len_t;
                        if (len_t == 7'd0) begin
                            snd_next = 1'b0;
                            stop = 1'b1;
                        end
                    end
                    // envelope
                    if (!stop && env_ctl_reg[8]) begin
                        cd = env_cd_reg - 3'd1;
                        if (cd == 3'd0) begin
                            if (env_ctl_reg[7]) begin
                                if (env_reg != 4'd15) env_next = env_reg + 4'd1;
                            end else begin
                                if (env_reg != 4'd0) env_next = env_reg - 4'd1;
                            end
                            env_cd_next = env_ctl_reg[6:4];
                        end else begin
                            env_cd_next = cd;
                        end
                    end
                    // frequency sweep
                    if (!stop && sweep_ctl_reg[7]) begin
                        cd = sw_cd_reg - 3'd1;
                        if (cd == 3'd0) begin
                            shifted = rate_reg >> sweep_ctl_reg[5:3];
                            r12 = sweep_ctl_reg[6] ? {1'b0, rate_reg} - {1'b0, shifted}
                                                   : {1'b0, rate_reg} + {1'b0, shifted};
                            if (r12[11]) begin
                                snd_next = 1'b0;
                            end else begin
                                rate_next = r12[10:0];
                                div_req_next = 1'b1;
                                sw_cd_next = sweep_ctl_reg[2:0];
                            end
                        end else begin
                            sw_cd_next = cd;
                        end
                    end
                end
            end
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = S_MUL;
            S_MUL: begin
                if (mcnt_reg == 4'(stc_pkg::MUL_N - 1)) begin
                    state_next = div_req_reg ? S_DIV : S_OUT;
                end
            end
            S_DIV: if (div_done) state_next = S_OUT;
            S_OUT: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign div_start = (state_reg == S_MUL) && (mcnt_reg == 4'(stc_pkg::MUL_N - 1))
                       && div_req_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= '0; step_reg <= '0; facc_reg <= '0; len_reg <= '0;
            env_reg <= '0; env_cd_reg <= '0; sw_cd_reg <= '0; rate_reg <= '0;
            snd_reg <= 1'b0; div_req_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next; facc_reg <= facc_next; len_reg <= len_next;
            env_reg <= env_next; env_cd_reg <= env_cd_next; sw_cd_reg <= sw_cd_next;
            rate_reg <= rate_next; snd_reg <= snd_next; div_req_reg <= div_req_next;
            if (div_done) step_reg <= div_q;
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // bit-serial volume multiply, both sides share the envelope weight
    always_ff @(posedge aclk) begin
        high_reg <= high_next;
        if (accept) begin
            mcand_reg <= 28'(e_next);
            cl_reg <= cl_next;
            cr_reg <= cr_next;
            pl_reg <= '0;
            pr_reg <= '0;
            mcnt_reg <= '0;
        end else if (state_reg == S_MUL) begin
            if (cl_reg[0]) pl_reg <= pl_reg + mcand_reg;
            if (cr_reg[0]) pr_reg <= pr_reg + mcand_reg;
            mcand_reg <= {mcand_reg[26:0], 1'b0};
            cl_reg <= {1'b0, cl_reg[12:1]};
            cr_reg <= {1'b0, cr_reg[12:1]};
            mcnt_reg <= mcnt_reg + 4'd1;
        end
    end

    // master scale, duty sign and final shift
    function automatic logic [9:0] finish(input logic [27:0] p, input logic [1:0] m,
                                          input logic hi);
        logic [33:0] v;
        logic [33:0] x;
        v = '0;
        case (m)
            2'd0:    v = 34'(p);
            2'd1:    v = 34'(p) << 1;
            2'd2:    v = 34'(p) << 2;
            default: v = '0;
        endcase
        x = hi ? (v << 3) - v : 34'd0 - (v << 3);
        finish = x[31:22];
    endfunction

    always_ff @(posedge aclk) begin
        if (state_reg == S_OUT && out_free) begin
            ml_reg <= finish(pl_reg, master_reg, high_reg);
            mr_reg <= finish(pr_reg, master_reg, high_reg);
            ma_reg <= snd_reg;
        end
    end

    stc_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rate     (rate_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_valid        = m_valid_reg;
    assign m_left_sample  = ml_reg;
    assign m_right_sample = mr_reg;
    assign m_active       = ma_reg;

    // divider only runs while the sequencer waits for it
    a_div_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> state_reg == S_DIV)
        else $error("divider busy outside divide state");

    // an accepted transaction always enters the multiply
    a_accept_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == S_MUL)
        else $error("accepted transaction skipped multiply");

    // a finished result waits while the output register is still held
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && m_valid_reg && !m_ready) |=> state_reg == S_OUT)
        else $error("result overwrote a pending transaction");

endmodule
`default_nettype wire

>>> verif/tb_top.sv
`default_nettype none
module tb_top;

    typedef struct packed {
        logic        cmd;
        logic [10:0] rate;
    } tone_item_t;

    typedef struct packed {
        logic signed [9:0] left;
        logic signed [9:0] right;
        logic              active;
    } tone_out_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_we;
    logic [2:0]        cfg_addr;
    logic [8:0]        cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    logic              s_command;
    logic [10:0]       s_start_rate;
    logic              m_valid;
    logic              m_ready;
    logic signed [9:0] m_left_sample;
    logic signed [9:0] m_right_sample;
    logic              m_active;

    square_tone_channel i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_command(s_command), .s_start_rate(s_start_rate),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_left_sample(m_left_sample), .m_right_sample(m_right_sample),
        .m_active(m_active)
    );

    // predictor copy of the registers and channel state
    logic [1:0]  p_duty, p_route, p_master;
    logic [2:0]  p_left, p_right;
    logic [7:0]  p_sweep;
    logic [8:0]  p_env;
    logic [6:0]  p_len;
    logic [18:0] t_phase;
    logic [23:0] t_step;
    logic [16:0] t_frame;
    logic [6:0]  t_length;
    logic [3:0]  t_vol;
    logic [2:0]  t_env_cd, t_sweep_cd;
    logic [10:0] t_rate;
    logic        t_on;

    tone_item_t pending_items[$];
    tone_out_t  expected_samples[$];
    int         mismatches = 0;
    int         results_seen = 0;
    int         restarts_sent = 0;
    bit         hold_sender = 0;
    int         stall_cycles = 0;

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #60000000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [23:0] step_of(input logic [10:0] rate);
        logic [63:0] den;
        den = 64'(stc_pkg::SAMPLE_RATE) * (64'd2048 - 64'(rate));
        return 24'((64'd1 << 36) / den);
    endfunction

    function automatic logic [9:0] level_of(input logic hi, input logic [2:0] pan);
        longint e, c, v, x;
        longint mf;
        e = (longint'(t_vol) << 14) / 15;
        c = (longint'(pan) << 12) / 7;
        case (p_master)
            2'd0: mf = 1;
            2'd1: mf = 2;
            2'd2: mf = 4;
            default: mf = 0;
        endcase
        v = e * c * mf;
        x = hi ? 7 * v : -8 * v;
        x = x + (longint'(1) << 31);
        return 10'((x >>> 22) - 512);
    endfunction

    // length, envelope and sweep clocked at frame rate
    task automatic frame_tick();
        logic [2:0]  cd;
        logic [11:0] nr;
        if (p_len[6]) begin
            t_length = t_length - 7'd1;
            if (t_length == 0) begin
                t_on = 0;
                return;
            end
        end
        if (p_env[8]) begin
            cd = t_env_cd - 3'd1;
            if (cd == 0) begin
                if (p_env[7]) begin
                    if (t_vol != 15) t_vol++;
                end else if (t_vol != 0) t_vol--;
                t_env_cd = p_env[6:4];
            end else t_env_cd = cd;
        end
        if (p_sweep[7]) begin
            cd = t_sweep_cd - 3'd1;
            if (cd == 0) begin
                if (p_sweep[6]) nr = 12'(t_rate) - 12'(t_rate >> p_sweep[5:3]);
                else nr = 12'(t_rate) + 12'(t_rate >> p_sweep[5:3]);
                if (nr > 2047) begin
                    t_on = 0;
                    return;
                end
                t_rate = nr[10:0];
                t_step = step_of(t_rate);
                cd = p_sweep[2:0];
            end
            t_sweep_cd = cd;
        end
    endtask

    task automatic predict_sample(input tone_item_t it);
        tone_out_t o;
        logic [7:0] pat;
        logic hi;
        o = '0;
        if (it.cmd == stc_pkg::CMD_RESTART) begin
            t_rate = it.rate;
            t_step = step_of(it.rate);
            t_phase = 0;
            t_frame = 0;
            t_length = (p_len[5:0] == 0) ? 7'd64 : 7'(p_len[5:0]);
            t_vol = p_env[3:0];
            t_env_cd = p_env[6:4];
            t_sweep_cd = p_sweep[2:0];
            t_on = 1;
        end else if (t_on && p_route != 0) begin
            case (p_duty)
                2'd0: pat = 8'h10;
                2'd1: pat = 8'h30;
                2'd2: pat = 8'h3C;
                default: pat = 8'hCF;
            endcase
            hi = pat[t_phase[18:16]];
            if (p_route[0]) o.left = level_of(hi, p_left);
            if (p_route[1]) o.right = level_of(hi, p_right);
            t_phase = t_phase + 19'(t_step);
            t_frame = t_frame + 17'(stc_pkg::FRAME_STEP);
            if (t_frame > 17'hFFFF) begin
                t_frame[16] = 0;
                frame_tick();
            end
        end
        o.active = t_on;
        expected_samples.push_back(o);
    endtask

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] exp);
        mismatches++;
        $display("mismatch %s at result %0d: got %0d expected %0d", what, results_seen, got, exp);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [8:0] val);
        @(posedge aclk);
        cfg_we <= 1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            stc_pkg::REG_DUTY:   p_duty = val[1:0];
            stc_pkg::REG_ROUTE:  p_route = val[1:0];
            stc_pkg::REG_LEFT:   p_left = val[2:0];
            stc_pkg::REG_RIGHT:  p_right = val[2:0];
            stc_pkg::REG_MASTER: p_master = val[1:0];
            stc_pkg::REG_SWEEP:  p_sweep = val[7:0];
            stc_pkg::REG_ENV:    p_env = val;
            stc_pkg::REG_LENGTH: p_len = val[6:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || expected_samples.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic push(input logic cmd, input logic [10:0] rate);
        tone_item_t it;
        it.cmd = cmd;
        it.rate = rate;
        if (cmd == stc_pkg::CMD_RESTART) restarts_sent++;
        pending_items.push_back(it);
    endtask

    task automatic random_setup();
        write_reg(stc_pkg::REG_DUTY, 9'($urandom_range(0, 3)));
        write_reg(stc_pkg::REG_ROUTE, 9'($urandom_range(0, 3)));
        write_reg(stc_pkg::REG_LEFT, 9'($urandom_range(0, 7)));
        write_reg(stc_pkg::REG_RIGHT, 9'($urandom_range(0, 7)));
        write_reg(stc_pkg::REG_MASTER, 9'($urandom_range(0, 3)));
        write_reg(stc_pkg::REG_SWEEP, 9'($urandom_range(0, 255)));
        write_reg(stc_pkg::REG_ENV, 9'($urandom_range(0, 511)));
        write_reg(stc_pkg::REG_LENGTH, 9'($urandom_range(0, 127)));
    endtask

    // driver: bursts of offers with random gaps
    int gap_left = 0;
    int burst_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_sample(pending_items.pop_front());
            end
            if (s_valid && !s_ready) begin
                // hold the offer
            end else if (pending_items.size() > 0 && !hold_sender && gap_left == 0) begin
                s_valid <= 1;
                s_command <= pending_items[0].cmd;
                s_start_rate <= pending_items[0].rate;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                end else begin
                    burst_left--;
                    if (burst_left == 0) gap_left = $urandom_range(0, 3) == 0 ?
                        $urandom_range(1, 60) : $urandom_range(0, 4);
                end
            end else begin
                s_valid <= 0;
                if (gap_left > 0) gap_left--;
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge aclk) begin
        tone_out_t e;
        if (!aresetn) begin
            m_ready <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    report("unexpected", 0, 0);
                end else begin
                    e = expected_samples.pop_front();
                    if (m_left_sample !== e.left) report("left", 16'(m_left_sample), 16'(e.left));
                    if (m_right_sample !== e.right)
                        report("right", 16'(m_right_sample), 16'(e.right));
                    if (m_active !== e.active) report("active", 16'(m_active), 16'(e.active));
                end
                results_seen++;
            end
            if (stall_cycles > 0) begin
                stall_cycles--;
                m_ready <= 0;
            end else if (results_seen % 200 < 60) begin
                m_ready <= 1;
            end else begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // long hold-off of the receiver while the sender keeps offering
    initial begin
        wait (results_seen > 300);
        stall_cycles = 600;
    end

    initial begin
        int phase_n;
        aresetn = 0;
        cfg_we = 0;
        cfg_addr = 0;
        cfg_wdata = 0;
        s_valid = 0;
        s_command = 0;
        s_start_rate = 0;
        m_ready = 0;
        p_duty = 2; p_route = 0; p_left = 0; p_right = 0; p_master = 0;
        p_sweep = 0; p_env = 0; p_len = 0;
        t_phase = 0; t_step = 0; t_frame = 0; t_length = 0; t_vol = 0;
        t_env_cd = 0; t_sweep_cd = 0; t_rate = 0; t_on = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1;

        // directed: silent ticks, then loud extremes and sweep edges
        push(stc_pkg::CMD_TICK, 11'h7FF);
        push(stc_pkg::CMD_RESTART, 11'h000);
        push(stc_pkg::CMD_TICK, 11'h000);
        drain();
        write_reg(stc_pkg::REG_ROUTE, 9'd3);
        write_reg(stc_pkg::REG_LEFT, 9'd7);
        write_reg(stc_pkg::REG_RIGHT, 9'd7);
        write_reg(stc_pkg::REG_MASTER, 9'd2);
        write_reg(stc_pkg::REG_ENV, 9'h00F);
        write_reg(stc_pkg::REG_DUTY, 9'd3);
        write_reg(stc_pkg::REG_SWEEP, 9'h081);
        write_reg(stc_pkg::REG_LENGTH, 9'h041);
        push(stc_pkg::CMD_RESTART, 11'h7FF);
        repeat (3) push(stc_pkg::CMD_TICK, 11'h555);
        push(stc_pkg::CMD_RESTART, 11'h400);
        repeat (4) push(stc_pkg::CMD_TICK, 11'h2AA);
        drain();
        write_reg(stc_pkg::REG_LENGTH, 9'h000);
        write_reg(stc_pkg::REG_SWEEP, 9'h080);
        write_reg(stc_pkg::REG_ENV, 9'h1FF);
        push(stc_pkg::CMD_RESTART, 11'h001);
        repeat (6) push(stc_pkg::CMD_TICK, 11'h000);
        drain();
        write_reg(stc_pkg::REG_MASTER, 9'd3);
        write_reg(stc_pkg::REG_ROUTE, 9'd1);
        write_reg(stc_pkg::REG_SWEEP, 9'h0C0);
        push(stc_pkg::CMD_RESTART, 11'h7FE);
        repeat (4) push(stc_pkg::CMD_TICK, 11'h000);
        drain();

        // random phases with mostly ticks after a restart
        for (phase_n = 0; phase_n < 10; phase_n++) begin
            random_setup();
            if (phase_n == 5) write_reg(stc_pkg::REG_LENGTH, 9'h07F);
            push(stc_pkg::CMD_RESTART, 11'($urandom_range(0, 2047)));
            repeat (100) begin
                if ($urandom_range(0, 49) == 0)
                    push(stc_pkg::CMD_RESTART, 11'($urandom_range(0, 2047)));
                else push(stc_pkg::CMD_TICK, 11'($urandom_range(0, 2047)));
            end
            if (phase_n == 3) begin
                // let part of the batch go, then pause until all results are back
                while (pending_items.size() > 50) @(posedge aclk);
                hold_sender = 1;
                while (expected_samples.size() != 0 || s_valid) @(posedge aclk);
                hold_sender = 0;
            end
            drain();
        end

        drain();
        $display("covered %0d results, %0d restarts, ten random register settings",
                 results_seen, restarts_sent);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> square_tone_channel.f
design/stc_pkg.sv
design/stc_divider.sv
design/square_tone_channel.sv
verif/tb_top.sv
